/* hw/rtl/dbct_pkg.sv */
// ----------------------------------------------------------------------------
// dbct_pkg
// Shared types and constants of the dark blob centroid tracker.
// ----------------------------------------------------------------------------
package dbct_pkg;

    localparam int XW        = 10;    // coordinate port width
    localparam int CH_W      = 8;     // color channel and intensity width
    localparam int CNT_W     = 21;    // kept pixel count width
    localparam int CFG_IDX_W = 2;
    localparam int CFG_W     = 11;
    localparam int RAD_W     = 11;
    localparam int LIM_SQ_W  = 23;    // radius*radius + radius
    localparam int QDEPTH    = 4;
    localparam int QPTR_W    = 2;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DARK_MODE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_RADIUS    = 2'd2;

    localparam logic [CH_W-1:0]  THRESHOLD_RST = 8'd20;
    localparam logic [RAD_W-1:0] RADIUS_RST    = 11'd50;

    // x of the center reported when no pixel was kept
    localparam logic [XW-1:0] EMPTY_X = 10'd7;

    // divide by three: (s * 683) >> 11 is exact for s up to 765
    localparam logic [9:0] RECIP_3     = 10'd683;
    localparam int         RECIP_SHIFT = 11;

    typedef struct packed {
        logic [CH_W-1:0]  threshold;
        logic             dark_mode;
        logic [RAD_W-1:0] radius;
    } cfg_t;

    typedef struct packed {
        logic            cmd;
        logic            last;
        logic            level_ok;
        logic [XW-1:0]   x;
        logic [XW-1:0]   y;
        logic [CH_W-1:0] inten;
    } item_t;

    typedef struct packed {
        logic [XW-1:0]    cx;
        logic [XW-1:0]    cy;
        logic [CH_W-1:0]  inten;
        logic             found;
        logic [CNT_W-1:0] count;
    } result_t;

endpackage

/* hw/rtl/dbct_front.sv */
// ----------------------------------------------------------------------------
// dbct_front
// Classifies an incoming item: pixel intensity and threshold check.
// ----------------------------------------------------------------------------
module dbct_front
    import dbct_pkg::*;
(
    input  cfg_t            cfg,
    input  logic            command,
    input  logic [XW-1:0]   pixel_x,
    input  logic [XW-1:0]   pixel_y,
    input  logic [CH_W-1:0] red,
    input  logic [CH_W-1:0] green,
    input  logic [CH_W-1:0] blue,
    input  logic            frame_last,
    output item_t           item
);

    logic [9:0]      chan_sum;
    logic [19:0]     scaled;
    logic [CH_W-1:0] inten;

    assign chan_sum = 10'(red) + 10'(green) + 10'(blue);
    assign scaled   = 20'(chan_sum) * 20'(RECIP_3);
    assign inten    = scaled[RECIP_SHIFT +: CH_W];

    always_comb
    begin
        item.cmd      = command;
        item.last     = frame_last;
        item.level_ok = cfg.dark_mode ? (inten < cfg.threshold) : (inten > cfg.threshold);
        item.x        = pixel_x;
        item.y        = pixel_y;
        item.inten    = inten;
    end

endmodule

/* hw/rtl/dbct_queue.sv */
// ----------------------------------------------------------------------------
// dbct_queue
// Short queue of classified items between the front and the back.
// ----------------------------------------------------------------------------
module dbct_queue
    import dbct_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  wr_en,
    input  item_t wr_item,
    output logic  full,
    input  logic  rd_en,
    output item_t rd_item,
    output logic  empty
);

    item_t              mem [QDEPTH];
    logic [QPTR_W-1:0]  wr_ptr_reg;
    logic [QPTR_W-1:0]  rd_ptr_reg;
    logic [QPTR_W:0]    cnt_reg;
    logic [QPTR_W:0]    cnt_next;

    assign full    = (cnt_reg == (QPTR_W+1)'(QDEPTH));
    assign empty   = (cnt_reg == '0);
    assign rd_item = mem[rd_ptr_reg];

    always_comb
    begin
        cnt_next = cnt_reg;
        if (wr_en && !rd_en)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (!wr_en && rd_en)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (wr_en)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (rd_en)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_ptr_reg] <= wr_item;
        end
    end

endmodule

/* hw/rtl/dbct_div.sv */
// ----------------------------------------------------------------------------
// dbct_div
// Three-lane restoring divider sharing one divisor, one quotient bit a cycle.
// ----------------------------------------------------------------------------
module dbct_div
    import dbct_pkg::*;
#(
    parameter int NW = 31
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [NW-1:0]    num_x,
    input  logic [NW-1:0]    num_y,
    input  logic [NW-1:0]    num_i,
    input  logic [CNT_W-1:0] den,
    input  logic             ack,
    output logic             busy,
    output logic             done,
    output logic [NW-1:0]    quo_x,
    output logic [NW-1:0]    quo_y,
    output logic [NW-1:0]    quo_i,
    output logic [CNT_W-1:0] den_out
);

    localparam int STEP_W = $clog2(NW);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_RUN  = 2'd1;
    localparam logic [1:0] S_DONE = 2'd2;

    logic [1:0]        state_reg;
    logic [1:0]        state_next;
    logic [STEP_W-1:0] step_reg;
    logic [CNT_W-1:0]  den_reg;
    logic [NW-1:0]     num_reg  [3];
    logic [CNT_W-1:0]  rem_reg  [3];
    logic [NW-1:0]     num_next [3];
    logic [CNT_W-1:0]  rem_next [3];
    logic [CNT_W:0]    trial    [3];

    // one restoring step per lane
    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            trial[k] = {rem_reg[k], num_reg[k][NW-1]};
            if (trial[k] >= {1'b0, den_reg})
            begin
                rem_next[k] = CNT_W'(trial[k] - {1'b0, den_reg});
                num_next[k] = {num_reg[k][NW-2:0], 1'b1};
            end
            else
            begin
                rem_next[k] = CNT_W'(trial[k]);
                num_next[k] = {num_reg[k][NW-2:0], 1'b0};
            end
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    state_next = S_RUN;
                end
            end
            S_RUN:
            begin
                if (step_reg == '0)
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (ack)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            step_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == S_IDLE && start)
            begin
                step_reg <= STEP_W'(NW - 1);
            end
            else if (state_reg == S_RUN)
            begin
                step_reg <= step_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && start)
        begin
            den_reg    <= den;
            num_reg[0] <= num_x;
            num_reg[1] <= num_y;
            num_reg[2] <= num_i;
            for (int k = 0; k < 3; k++)
            begin
                rem_reg[k] <= '0;
            end
        end
        else if (state_reg == S_RUN)
        begin
            for (int k = 0; k < 3; k++)
            begin
                num_reg[k] <= num_next[k];
                rem_reg[k] <= rem_next[k];
            end
        end
    end

    assign busy    = (state_reg != S_IDLE);
    assign done    = (state_reg == S_DONE);
    assign quo_x   = num_reg[0];
    assign quo_y   = num_reg[1];
    assign quo_i   = num_reg[2];
    assign den_out = den_reg;

endmodule

/* hw/rtl/dbct_back.sv */
// ----------------------------------------------------------------------------
// dbct_back
// Distance test, accumulation, frame-end division and result register.
// ----------------------------------------------------------------------------
module dbct_back
    import dbct_pkg::*;
#(
    parameter int CW = 10
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic [RAD_W-1:0] radius,
    input  item_t            head,
    input  logic             q_empty,
    output logic             q_pop,
    output result_t          res,
    output logic             res_empty,
    input  logic             res_pop
);

    localparam int SQ_W  = 2 * CW;
    localparam int SW    = (SQ_W + 1 > LIM_SQ_W) ? SQ_W + 1 : LIM_SQ_W;
    localparam int SXW   = CW + CNT_W;
    localparam int SIW   = CH_W + CNT_W;
    localparam int NW    = (SXW > SIW) ? SXW : SIW;

    logic [LIM_SQ_W-1:0] lim_sq_reg;

    // previous center
    logic [CW-1:0] prev_x_reg;
    logic [CW-1:0] prev_y_reg;

    // stage a
    logic            a_valid_reg;
    logic            a_last_reg;
    logic            a_level_reg;
    logic [CW-1:0]   a_x_reg;
    logic [CW-1:0]   a_y_reg;
    logic [CH_W-1:0] a_inten_reg;
    logic [SQ_W-1:0] a_dx2_reg;
    logic [SQ_W-1:0] a_dy2_reg;

    // accumulators
    logic [SXW-1:0]   sum_x_reg;
    logic [SXW-1:0]   sum_y_reg;
    logic [SIW-1:0]   sum_i_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [SXW-1:0]   sum_x_next;
    logic [SXW-1:0]   sum_y_next;
    logic [SIW-1:0]   sum_i_next;
    logic [CNT_W-1:0] cnt_next;

    logic [CW-1:0] hx;
    logic [CW-1:0] hy;
    logic [CW-1:0] dx;
    logic [CW-1:0] dy;
    logic          near_ok;
    logic          keep;
    logic          a_go;
    logic          div_start;

    logic             div_busy;
    logic             div_done;
    logic             capture;
    logic [NW-1:0]    quo_x;
    logic [NW-1:0]    quo_y;
    logic [NW-1:0]    quo_i;
    logic [CNT_W-1:0] div_den;

    logic    res_valid_reg;
    result_t res_reg;

    assign hx = CW'(head.x);
    assign hy = CW'(head.y);
    assign dx = (hx >= prev_x_reg) ? hx - prev_x_reg : prev_x_reg - hx;
    assign dy = (hy >= prev_y_reg) ? hy - prev_y_reg : prev_y_reg - hy;

    // a center change is pending while a frame end is in stage a or dividing
    assign q_pop = !q_empty && !div_busy && !(a_valid_reg && a_last_reg);

    assign a_go      = a_valid_reg && !(a_last_reg && div_busy);
    assign div_start = a_go && a_last_reg;

    assign near_ok = (SW'(a_dx2_reg) + SW'(a_dy2_reg)) <= SW'(lim_sq_reg);
    assign keep    = a_go && a_level_reg && near_ok && !cnt_reg[CNT_W-1];

    always_comb
    begin
        sum_x_next = sum_x_reg;
        sum_y_next = sum_y_reg;
        sum_i_next = sum_i_reg;
        cnt_next   = cnt_reg;
        if (keep)
        begin
            sum_x_next = sum_x_reg + SXW'(a_x_reg);
            sum_y_next = sum_y_reg + SXW'(a_y_reg);
            sum_i_next = sum_i_reg + SIW'(a_inten_reg);
            cnt_next   = cnt_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        lim_sq_reg <= LIM_SQ_W'(radius) * LIM_SQ_W'(radius) + LIM_SQ_W'(radius);
        if (q_pop && !head.cmd)
        begin
            a_last_reg  <= head.last;
            a_level_reg <= head.level_ok;
            a_x_reg     <= hx;
            a_y_reg     <= hy;
            a_inten_reg <= head.inten;
            a_dx2_reg   <= SQ_W'(dx) * SQ_W'(dx);
            a_dy2_reg   <= SQ_W'(dy) * SQ_W'(dy);
        end
    end

    dbct_div #(
        .NW (NW)
    ) u_div (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (div_start),
        .num_x   (NW'(sum_x_next)),
        .num_y   (NW'(sum_y_next)),
        .num_i   (NW'(sum_i_next)),
        .den     (cnt_next),
        .ack     (capture),
        .busy    (div_busy),
        .done    (div_done),
        .quo_x   (quo_x),
        .quo_y   (quo_y),
        .quo_i   (quo_i),
        .den_out (div_den)
    );

    assign capture = div_done && (!res_valid_reg || res_pop);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg   <= 1'b0;
            prev_x_reg    <= '0;
            prev_y_reg    <= '0;
            sum_x_reg     <= '0;
            sum_y_reg     <= '0;
            sum_i_reg     <= '0;
            cnt_reg       <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            if (q_pop)
            begin
                a_valid_reg <= !head.cmd;
            end
            else if (a_go)
            begin
                a_valid_reg <= 1'b0;
            end

            if (q_pop && head.cmd)
            begin
                prev_x_reg <= hx;
                prev_y_reg <= hy;
            end
            else if (capture && div_den != '0 && quo_x != '0 && quo_y != '0)
            begin
                prev_x_reg <= CW'(quo_x);
                prev_y_reg <= CW'(quo_y);
            end

            if (div_start)
            begin
                sum_x_reg <= '0;
                sum_y_reg <= '0;
                sum_i_reg <= '0;
                cnt_reg   <= '0;
            end
            else
            begin
                sum_x_reg <= sum_x_next;
                sum_y_reg <= sum_y_next;
                sum_i_reg <= sum_i_next;
                cnt_reg   <= cnt_next;
            end

            if (capture)
            begin
                res_valid_reg <= 1'b1;
            end
            else if (res_pop)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (capture)
        begin
            res_reg.count <= div_den;
            if (div_den == '0)
            begin
                res_reg.cx    <= EMPTY_X;
                res_reg.cy    <= '0;
                res_reg.inten <= '0;
                res_reg.found <= 1'b0;
            end
            else
            begin
                res_reg.cx    <= XW'(quo_x);
                res_reg.cy    <= XW'(quo_y);
                res_reg.inten <= CH_W'(quo_i);
                res_reg.found <= 1'b1;
            end
        end
    end

    assign res       = res_reg;
    assign res_empty = !res_valid_reg;

endmodule

/* hw/rtl/dark_blob_centroid_tracker.sv */
// ----------------------------------------------------------------------------
// dark_blob_centroid_tracker
// Thresholded blob centroid tracker over a stream of rgb pixels.
// ----------------------------------------------------------------------------
// Pixels stream in one per clock while the queue is not full: each pushed
// item is classified by its intensity floor((r+g+b)/3) against the threshold
// (dark or light mode) and parked in a four-entry queue; the back end pops
// one pixel per clock while no frame end is pending, tests its distance to
// the previous center (dx*dx+dy*dy <= limit*limit+limit) and accumulates kept
// pixels. A pixel with frame_last set closes the frame: the back end then
// runs a three-lane divider for the means, one quotient bit at a time, and
// pops nothing else until the new center is settled, so the queue absorbs the
// first pixels of the next frame. A set-center command moves the center as
// it is popped. Results leave through a one-deep output register, so the
// back end keeps working while a result waits to be popped. Configuration
// writes are taken every cycle and must only happen while the block is idle.
// ----------------------------------------------------------------------------
module dark_blob_centroid_tracker
    import dbct_pkg::*;
#(
    parameter int COORD_BITS = 10
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    // pixel input
    input  logic                 push,
    output logic                 full,
    input  logic                 command,
    input  logic [XW-1:0]        pixel_x,
    input  logic [XW-1:0]        pixel_y,
    input  logic [CH_W-1:0]      red,
    input  logic [CH_W-1:0]      green,
    input  logic [CH_W-1:0]      blue,
    input  logic                 frame_last,
    // result output
    output logic                 empty,
    input  logic                 pop,
    output logic [XW-1:0]        centroid_x,
    output logic [XW-1:0]        centroid_y,
    output logic [CH_W-1:0]      mean_intensity,
    output logic                 found,
    output logic [CNT_W-1:0]     kept_count,
    // configuration write
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data
);

    cfg_t    cfg_reg;
    item_t   front_item;
    item_t   head_item;
    logic    q_empty;
    logic    q_pop;
    logic    push_ok;
    result_t res;

    // config writes are always accepted
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.threshold <= THRESHOLD_RST;
            cfg_reg.dark_mode <= 1'b1;
            cfg_reg.radius    <= RADIUS_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_THRESHOLD: cfg_reg.threshold <= cfg_data[CH_W-1:0];
                REG_DARK_MODE: cfg_reg.dark_mode <= cfg_data[0];
                REG_RADIUS:    cfg_reg.radius    <= cfg_data[RAD_W-1:0];
                default:
                begin
                    // unknown index, write dropped
                    cfg_reg <= cfg_reg;
                end
            endcase
        end
    end

    // front: intensity and threshold classification
    dbct_front u_front (
        .cfg        (cfg_reg),
        .command    (command),
        .pixel_x    (pixel_x),
        .pixel_y    (pixel_y),
        .red        (red),
        .green      (green),
        .blue       (blue),
        .frame_last (frame_last),
        .item       (front_item)
    );

    // a transaction on the input side
    assign push_ok = push && !full;

    dbct_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (push_ok),
        .wr_item (front_item),
        .full    (full),
        .rd_en   (q_pop),
        .rd_item (head_item),
        .empty   (q_empty)
    );

    // back: distance test, sums, frame-end division, result register
    dbct_back #(
        .CW (COORD_BITS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .radius    (cfg_reg.radius),
        .head      (head_item),
        .q_empty   (q_empty),
        .q_pop     (q_pop),
        .res       (res),
        .res_empty (empty),
        .res_pop   (pop && !empty)
    );

    assign centroid_x     = res.cx;
    assign centroid_y     = res.cy;
    assign mean_intensity = res.inten;
    assign found          = res.found;
    assign kept_count     = res.count;

endmodule

/* bench/dbct_tb_pkg.sv */
// ----------------------------------------------------------------------------
// dbct_tb_pkg
// Codes and random helpers shared by the tracker checker and testbench.
// ----------------------------------------------------------------------------
package dbct_tb_pkg;

    import dbct_pkg::*;

    // command field codes
    localparam logic CMD_PIXEL      = 1'b0;
    localparam logic CMD_SET_CENTER = 1'b1;

    // register index with nothing behind it
    localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;

    // kept pixel count saturates here
    localparam logic [CNT_W-1:0] KEEP_CAP = 21'h100000;

    // idle length: mostly none, often short, now and then long
    function automatic int unsigned pick_gap();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 55)
            return 0;
        else if (roll < 90)
            return $urandom_range(1, 3);
        else
            return $urandom_range(8, 40);
    endfunction

endpackage

/* bench/dbct_checker.sv */
// ----------------------------------------------------------------------------
// dbct_checker
// Centroid predictor and result scoreboard for the blob centroid tracker.
// ----------------------------------------------------------------------------
// Watches the pixel, result and register channels, works out each frame's
// centroid from the accepted pixels and compares it with the popped result.
// ----------------------------------------------------------------------------
module dbct_checker
    import dbct_pkg::*;
    import dbct_tb_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  logic                 full,
    input  logic                 command,
    input  logic [XW-1:0]        pixel_x,
    input  logic [XW-1:0]        pixel_y,
    input  logic [CH_W-1:0]      red,
    input  logic [CH_W-1:0]      green,
    input  logic [CH_W-1:0]      blue,
    input  logic                 frame_last,
    input  logic                 empty,
    input  logic                 pop,
    input  logic [XW-1:0]        centroid_x,
    input  logic [XW-1:0]        centroid_y,
    input  logic [CH_W-1:0]      mean_intensity,
    input  logic                 found,
    input  logic [CNT_W-1:0]     kept_count,
    input  logic                 cfg_valid,
    input  logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    output int                   fail_count,
    output int                   pending_results
);

    timeunit 1ns;
    timeprecision 1ps;

    logic [CH_W-1:0]  threshold;
    logic             dark_mode;
    logic [RAD_W-1:0] radius;

    logic [29:0]      sum_x;
    logic [29:0]      sum_y;
    logic [27:0]      sum_level;
    logic [CNT_W-1:0] kept;
    logic [XW-1:0]    track_x;
    logic [XW-1:0]    track_y;

    result_t          centroid_queue[$];
    result_t          oldest;
    int               fails = 0;

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            fails++;
        end
    endtask

    // classify one pixel, accumulate it and close the frame on its last pixel
    task automatic track_pixel(input logic [XW-1:0] x, input logic [XW-1:0] y,
                               input logic [CH_W-1:0] r, input logic [CH_W-1:0] g,
                               input logic [CH_W-1:0] b, input logic last);
        logic [9:0]      chan_sum;
        logic [CH_W-1:0] level;
        logic            level_ok;
        logic [XW-1:0]   dx;
        logic [XW-1:0]   dy;
        logic [22:0]     dist_sq;
        logic [22:0]     reach_sq;
        logic [29:0]     mean_x;
        logic [29:0]     mean_y;
        logic [27:0]     mean_level;
        result_t         res;

        chan_sum = 10'(r) + 10'(g) + 10'(b);
        level    = CH_W'(chan_sum / 10'd3);
        level_ok = dark_mode ? (level < threshold) : (level > threshold);
        dx       = (x >= track_x) ? x - track_x : track_x - x;
        dy       = (y >= track_y) ? y - track_y : track_y - y;
        dist_sq  = 23'(dx) * 23'(dx) + 23'(dy) * 23'(dy);
        reach_sq = 23'(radius) * 23'(radius) + 23'(radius);

        if (level_ok && dist_sq <= reach_sq && kept < KEEP_CAP) begin
            sum_x     = sum_x + 30'(x);
            sum_y     = sum_y + 30'(y);
            sum_level = sum_level + 28'(level);
            kept      = kept + 1'b1;
        end

        if (last) begin
            if (kept == '0) begin
                res.cx    = EMPTY_X;
                res.cy    = '0;
                res.inten = '0;
                res.found = 1'b0;
                res.count = '0;
            end
            else begin
                mean_x     = sum_x / 30'(kept);
                mean_y     = sum_y / 30'(kept);
                mean_level = sum_level / 28'(kept);
                res.cx     = mean_x[XW-1:0];
                res.cy     = mean_y[XW-1:0];
                res.inten  = mean_level[CH_W-1:0];
                res.found  = 1'b1;
                res.count  = kept;
                // a zero coordinate leaves the tracked center alone
                if (res.cx != '0 && res.cy != '0) begin
                    track_x = res.cx;
                    track_y = res.cy;
                end
            end
            centroid_queue.push_back(res);
            sum_x     = '0;
            sum_y     = '0;
            sum_level = '0;
            kept      = '0;
        end
    endtask

    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            threshold = THRESHOLD_RST;
            dark_mode = 1'b1;
            radius    = RADIUS_RST;
            sum_x     = '0;
            sum_y     = '0;
            sum_level = '0;
            kept      = '0;
            track_x   = '0;
            track_y   = '0;
            centroid_queue.delete();
            pending_results <= 0;
            fail_count      <= fails;
        end
        else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    REG_THRESHOLD: threshold = cfg_data[CH_W-1:0];
                    REG_DARK_MODE: dark_mode = cfg_data[0];
                    REG_RADIUS:    radius    = cfg_data[RAD_W-1:0];
                    default:       ;
                endcase
            end

            // compare before predicting: a result never leaves on its own push edge
            if (pop && !empty) begin
                if (centroid_queue.size() == 0) begin
                    $error("unexpected result: centroid_x %0d centroid_y %0d count %0d",
                           centroid_x, centroid_y, kept_count);
                    fails++;
                end
                else begin
                    oldest = centroid_queue.pop_front();
                    check_field("centroid_x", 32'(oldest.cx), 32'(centroid_x));
                    check_field("centroid_y", 32'(oldest.cy), 32'(centroid_y));
                    check_field("mean_intensity", 32'(oldest.inten),
                                32'(mean_intensity));
                    check_field("found", 32'(oldest.found), 32'(found));
                    check_field("kept_count", 32'(oldest.count), 32'(kept_count));
                end
            end

            if (push && !full) begin
                if (command == CMD_SET_CENTER) begin
                    track_x = pixel_x;
                    track_y = pixel_y;
                end
                else
                    track_pixel(pixel_x, pixel_y, red, green, blue, frame_last);
            end

            pending_results <= centroid_queue.size();
            fail_count      <= fails;
        end
    end

endmodule

/* bench/dark_blob_centroid_tracker_tb.sv */
// ----------------------------------------------------------------------------
// dark_blob_centroid_tracker_tb
// Regression for the thresholded blob centroid tracker.
// ----------------------------------------------------------------------------
// Streams directed and random pixel frames through the tracker under several
// register settings, with random idle gaps on the pixel side and random pop
// stalls on the result side. A checker beside the block predicts every frame
// centroid and compares it with what pops out.
// ----------------------------------------------------------------------------
module dark_blob_centroid_tracker_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import dbct_pkg::*;
    import dbct_tb_pkg::*;

    // cycles to let the divider and center update settle after a frame end
    localparam int SETTLE_CYCLES = 64;

    logic                 clk        = 1'b0;
    logic                 rst_n      = 1'b0;
    logic                 push       = 1'b0;
    logic                 full;
    logic                 command    = CMD_PIXEL;
    logic [XW-1:0]        pixel_x    = '0;
    logic [XW-1:0]        pixel_y    = '0;
    logic [CH_W-1:0]      red        = '0;
    logic [CH_W-1:0]      green      = '0;
    logic [CH_W-1:0]      blue       = '0;
    logic                 frame_last = 1'b0;
    logic                 empty;
    logic                 pop        = 1'b0;
    logic [XW-1:0]        centroid_x;
    logic [XW-1:0]        centroid_y;
    logic [CH_W-1:0]      mean_intensity;
    logic                 found;
    logic [CNT_W-1:0]     kept_count;
    logic                 cfg_valid  = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index  = REG_THRESHOLD;
    logic [CFG_W-1:0]     cfg_data   = '0;

    int                   fail_count;
    int                   pending_results;

    // idle control: steady_push is only used by the stimulus process,
    // steady_pop crosses into the pop process so it moves by nonblocking writes
    bit                   steady_push = 1'b0;
    bit                   steady_pop  = 1'b0;
    int unsigned          pop_hold    = 0;

    // settings as last written, used to steer random pixels toward the keep side
    logic [CH_W-1:0]      cur_threshold = THRESHOLD_RST;
    logic                 cur_dark      = 1'b1;
    logic [RAD_W-1:0]     cur_radius    = RADIUS_RST;

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    dark_blob_centroid_tracker dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .push           (push),
        .full           (full),
        .command        (command),
        .pixel_x        (pixel_x),
        .pixel_y        (pixel_y),
        .red            (red),
        .green          (green),
        .blue           (blue),
        .frame_last     (frame_last),
        .empty          (empty),
        .pop            (pop),
        .centroid_x     (centroid_x),
        .centroid_y     (centroid_y),
        .mean_intensity (mean_intensity),
        .found          (found),
        .kept_count     (kept_count),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data)
    );

    dbct_checker u_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .push            (push),
        .full            (full),
        .command         (command),
        .pixel_x         (pixel_x),
        .pixel_y         (pixel_y),
        .red             (red),
        .green           (green),
        .blue            (blue),
        .frame_last      (frame_last),
        .empty           (empty),
        .pop             (pop),
        .centroid_x      (centroid_x),
        .centroid_y      (centroid_y),
        .mean_intensity  (mean_intensity),
        .found           (found),
        .kept_count      (kept_count),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .fail_count      (fail_count),
        .pending_results (pending_results)
    );

    // result side: pop high by default, with random stalls unless steady
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            pop      <= 1'b0;
            pop_hold <= 0;
        end
        else if (pop_hold != 0)
        begin
            pop      <= 1'b0;
            pop_hold <= pop_hold - 1;
        end
        else
        begin
            pop <= 1'b1;
            if (!steady_pop && $urandom_range(0, 2) == 0)
                pop_hold <= pick_gap();
        end
    end

    // one pixel-side transaction, with an optional idle gap before it;
    // push stays high when the next transaction follows straight away
    task automatic send_item(input logic cmd, input logic [XW-1:0] x,
                             input logic [XW-1:0] y, input logic [CH_W-1:0] r,
                             input logic [CH_W-1:0] g, input logic [CH_W-1:0] b,
                             input logic last);
        int unsigned gap;
        gap = steady_push ? 0 : pick_gap();
        if (gap != 0)
        begin
            // junk on the data lines while push is low
            push       <= 1'b0;
            command    <= 1'($urandom);
            pixel_x    <= XW'($urandom);
            pixel_y    <= XW'($urandom);
            red        <= CH_W'($urandom);
            green      <= CH_W'($urandom);
            blue       <= CH_W'($urandom);
            frame_last <= 1'($urandom);
            repeat (gap) @(posedge clk);
        end
        command    <= cmd;
        pixel_x    <= x;
        pixel_y    <= y;
        red        <= r;
        green      <= g;
        blue       <= b;
        frame_last <= last;
        push       <= 1'b1;
        do @(posedge clk); while (full);
    endtask

    // register write transaction; valid drops between writes
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_W-1:0] value);
        cfg_index <= idx;
        cfg_data  <= value;
        cfg_valid <= 1'b1;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        @(posedge clk);
        case (idx)
            REG_THRESHOLD: cur_threshold = value[CH_W-1:0];
            REG_DARK_MODE: cur_dark      = value[0];
            REG_RADIUS:    cur_radius    = value[RAD_W-1:0];
            default:       ;
        endcase
    endtask

    // stop pushing, wait for every predicted frame result, then let the
    // back end finish any center update or trailing pixels
    task automatic drain();
        push <= 1'b0;
        do @(posedge clk); while (pending_results != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    initial
    begin
        int          phase;
        int          sent;
        int          frame_len;
        int          i;
        int          n;
        int          aim_x;
        int          aim_y;
        int          span;
        int          x;
        int          y;
        int          lo;
        int          hi;
        int          sum;
        int          rest;
        int          r;
        int          g;
        logic        last;
        logic        keep_possible;
        logic [CH_W-1:0]  thr;
        logic             dark;
        logic [RAD_W-1:0] rad;

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // ---------------- directed part, reset settings ----------------
        // threshold 20, dark mode, radius 50, tracked center at origin

        // brightest pixel is never dark: empty frame gives the fallback
        send_item(CMD_PIXEL, 10'd5, 10'd5, 8'd255, 8'd255, 8'd255, 1'b1);
        // set center; frame_last and channels on a command are ignored
        send_item(CMD_SET_CENTER, 10'd100, 10'd200, 8'd255, 8'd0, 8'd255, 1'b1);
        // pixel on the center
        send_item(CMD_PIXEL, 10'd100, 10'd200, 8'd0, 8'd0, 8'd0, 1'b0);
        // exactly on the radius
        send_item(CMD_PIXEL, 10'd150, 10'd200, 8'd19, 8'd19, 8'd19, 1'b0);
        // one past the radius
        send_item(CMD_PIXEL, 10'd151, 10'd200, 8'd0, 8'd0, 8'd0, 1'b0);
        // distance 50.49 rounds down: kept; intensity floors to 19
        send_item(CMD_PIXEL, 10'd150, 10'd207, 8'd20, 8'd19, 8'd19, 1'b0);
        // distance 50.64 rounds up: dropped
        send_item(CMD_PIXEL, 10'd150, 10'd208, 8'd0, 8'd0, 8'd0, 1'b0);
        // intensity equal to the threshold is not dark
        send_item(CMD_PIXEL, 10'd100, 10'd200, 8'd20, 8'd20, 8'd20, 1'b0);
        // 59/3 floors to 19: kept, closes the frame
        send_item(CMD_PIXEL, 10'd100, 10'd200, 8'd21, 8'd19, 8'd19, 1'b1);
        // center back to the origin, zeros included
        send_item(CMD_SET_CENTER, 10'd0, 10'd0, 8'd7, 8'd7, 8'd7, 1'b0);
        // mean x of zero: tracked center must stay put
        send_item(CMD_PIXEL, 10'd0, 10'd0, 8'd0, 8'd0, 8'd0, 1'b0);
        send_item(CMD_PIXEL, 10'd0, 10'd30, 8'd1, 8'd2, 8'd3, 1'b1);
        // mean y of zero: same
        send_item(CMD_PIXEL, 10'd30, 10'd0, 8'd0, 8'd0, 8'd0, 1'b1);

        // light mode, threshold zero, widest radius
        drain();
        write_reg(REG_DARK_MODE, 11'd0);
        write_reg(REG_THRESHOLD, 11'd0);
        write_reg(REG_RADIUS, 11'd2047);
        send_item(CMD_SET_CENTER, 10'd1023, 10'd1023, 8'd0, 8'd0, 8'd0, 1'b0);
        send_item(CMD_PIXEL, 10'd1023, 10'd1023, 8'd255, 8'd255, 8'd255, 1'b0);
        // intensity zero is not above zero
        send_item(CMD_PIXEL, 10'd0, 10'd0, 8'd1, 8'd0, 8'd0, 1'b0);
        send_item(CMD_PIXEL, 10'd0, 10'd0, 8'd1, 8'd1, 8'd1, 1'b1);

        // dark mode, top threshold, zero radius: only the exact center counts
        drain();
        write_reg(REG_DARK_MODE, 11'd1);
        write_reg(REG_THRESHOLD, 11'd255);
        write_reg(REG_RADIUS, 11'd0);
        write_reg(REG_SPARE, 11'h7ff);
        send_item(CMD_SET_CENTER, 10'd512, 10'd512, 8'd0, 8'd0, 8'd0, 1'b0);
        send_item(CMD_PIXEL, 10'd512, 10'd512, 8'd254, 8'd254, 8'd254, 1'b0);
        send_item(CMD_PIXEL, 10'd513, 10'd512, 8'd0, 8'd0, 8'd0, 1'b0);
        send_item(CMD_PIXEL, 10'd512, 10'd511, 8'd0, 8'd0, 8'd0, 1'b1);

        // ---------------- random frames under several settings ----------------
        for (phase = 0; phase < 8; phase++)
        begin
            drain();

            thr  = CH_W'($urandom);
            dark = 1'($urandom);
            rad  = ($urandom_range(0, 2) == 0) ? RAD_W'($urandom)
                                               : RAD_W'($urandom_range(1, 120));
            // the first phases pin the extremes of each register
            case (phase)
                0: begin thr = 8'd0;   dark = 1'b0; end
                1: begin thr = 8'd255; dark = 1'b1; end
                2: rad = 11'd0;
                3: rad = 11'd2047;
                default: ;
            endcase

            // upper data bits beyond each register carry junk
            write_reg(REG_THRESHOLD, {3'($urandom), thr});
            write_reg(REG_DARK_MODE, {10'($urandom), dark});
            write_reg(REG_RADIUS, rad);
            if ($urandom_range(0, 1) == 1)
                write_reg(REG_SPARE, CFG_W'($urandom));

            steady_push = ($urandom_range(0, 3) == 0);
            steady_pop <= ($urandom_range(0, 3) == 0);

            span = int'(cur_radius) + 2;
            if (span > 1023)
                span = 1023;
            keep_possible = cur_dark ? (cur_threshold != 0) : (cur_threshold != 255);
            if (cur_dark)
            begin
                lo = 0;
                hi = 3 * int'(cur_threshold) - 1;
            end
            else
            begin
                lo = 3 * int'(cur_threshold) + 3;
                hi = 765;
            end

            sent = 0;
            aim_x = $urandom_range(0, 1023);
            aim_y = $urandom_range(0, 1023);
            while (sent < 85)
            begin
                // most frames start by seeding the center, now and then with a zero
                if ($urandom_range(0, 9) < 6)
                begin
                    aim_x = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(0, 1023);
                    aim_y = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(0, 1023);
                    send_item(CMD_SET_CENTER, XW'(aim_x), XW'(aim_y), CH_W'($urandom),
                              CH_W'($urandom), CH_W'($urandom), 1'($urandom));
                    sent++;
                end

                frame_len = ($urandom_range(0, 4) == 0) ? $urandom_range(13, 40)
                                                        : $urandom_range(1, 12);
                for (i = 0; i < frame_len; i++)
                begin
                    last = (i == frame_len - 1);

                    // an occasional center move in mid-frame
                    if (!last && $urandom_range(0, 24) == 0)
                    begin
                        aim_x = $urandom_range(0, 1023);
                        aim_y = $urandom_range(0, 1023);
                        send_item(CMD_SET_CENTER, XW'(aim_x), XW'(aim_y),
                                  CH_W'($urandom), CH_W'($urandom), CH_W'($urandom),
                                  1'b0);
                        sent++;
                    end

                    // coordinates: noise, dead on the center, or inside a box
                    // around it that straddles the radius
                    n = $urandom_range(0, 99);
                    if (n < 15)
                    begin
                        x = $urandom_range(0, 1023);
                        y = $urandom_range(0, 1023);
                    end
                    else if (n < 30)
                    begin
                        x = aim_x;
                        y = aim_y;
                    end
                    else
                    begin
                        x = aim_x + int'($urandom_range(0, 2 * span)) - span;
                        y = aim_y + int'($urandom_range(0, 2 * span)) - span;
                    end
                    x = (x < 0) ? 0 : (x > 1023) ? 1023 : x;
                    y = (y < 0) ? 0 : (y > 1023) ? 1023 : y;

                    // channel sum: mostly on the keep side of the threshold
                    if (keep_possible && $urandom_range(0, 9) < 7)
                        sum = $urandom_range(lo, hi);
                    else
                        sum = $urandom_range(0, 765);
                    r    = $urandom_range((sum > 510) ? sum - 510 : 0, (sum < 255) ? sum : 255);
                    rest = sum - r;
                    g    = $urandom_range((rest > 255) ? rest - 255 : 0,
                                          (rest < 255) ? rest : 255);

                    send_item(CMD_PIXEL, XW'(x), XW'(y), CH_W'(r), CH_W'(g),
                              CH_W'(rest - g), last);
                    sent++;
                end
            end
        end

        drain();
        if (fail_count == 0 && pending_results == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    // watchdog, several times the slowest legal run
    initial
    begin
        #100_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule
